// File: design/ffa_pkg.sv
// ---------------------------------------------------------------------------
// ffa_pkg: shared types and codes of the first-fit free-list allocator
// Region entry layout, action and status codes, controller/datapath links.
// ---------------------------------------------------------------------------
package ffa_pkg;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_NOFIT = 2'd1;
  localparam logic [1:0] STATUS_DROP  = 2'd2;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
  } region_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ALLOC_FAIL,
    OP_ALLOC_TRIM,
    OP_ALLOC_TAKE,
    OP_MERGE_BOTH,
    OP_MERGE_LO,
    OP_MERGE_HI,
    OP_INSERT,
    OP_DROP
  } ffa_op_t;

  typedef struct packed {
    logic    load;
    logic    scan;
    logic    decide;
    ffa_op_t op;
    logic    shdn;
    logic    shup;
    logic    publish;
  } ffa_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic is_free;
    logic lo_ok;
    logic hi_ok;
    logic exact;
    logic full;
    logic shdn_done;
    logic shup_done;
    logic out_busy;
  } ffa_stat_t;

endpackage

// File: design/ffa_in_if.sv
// ---------------------------------------------------------------------------
// ffa_in_if: request channel
// Valid/ready channel carrying one allocate or free request per transfer.
// ---------------------------------------------------------------------------
interface ffa_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] block_addr;
  logic [31:0] block_size;

  modport source (output valid, output action, output block_addr, output block_size,
                  input ready);
  modport sink   (input valid, input action, input block_addr, input block_size,
                  output ready);
endinterface

// File: design/ffa_out_if.sv
// ---------------------------------------------------------------------------
// ffa_out_if: result channel
// Valid/ready channel carrying one result per transfer.
// ---------------------------------------------------------------------------
interface ffa_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] alloc_addr;
  logic [31:0] free_total;
  logic [8:0]  entries_used;
  logic [8:0]  entries_peak;
  logic [31:0] lost_count;
  logic [31:0] lost_bytes;

  modport source (output valid, output status, output alloc_addr, output free_total,
                  output entries_used, output entries_peak, output lost_count,
                  output lost_bytes, input ready);
  modport sink   (input valid, input status, input alloc_addr, input free_total,
                  input entries_used, input entries_peak, input lost_count,
                  input lost_bytes, output ready);
endinterface

// File: design/ffa_ram.sv
// ---------------------------------------------------------------------------
// ffa_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module ffa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/ffa_ctrl.sv
// ---------------------------------------------------------------------------
// ffa_ctrl: allocator sequencer
// Steps each request through scan, decision, entry shifting and result.
// ---------------------------------------------------------------------------
module ffa_ctrl import ffa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ffa_stat_t stat,
  output ffa_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_SHDN   = 6'b001000,
    S_SHUP   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t  state_r, state_nxt;
  ffa_op_t op;

  always_comb begin
    if (!stat.is_free) begin
      if (!stat.found) begin
        op = OP_ALLOC_FAIL;
      end else if (stat.exact) begin
        op = OP_ALLOC_TAKE;
      end else begin
        op = OP_ALLOC_TRIM;
      end
    end else if (stat.lo_ok && stat.hi_ok) begin
      op = OP_MERGE_BOTH;
    end else if (stat.lo_ok) begin
      op = OP_MERGE_LO;
    end else if (stat.hi_ok) begin
      op = OP_MERGE_HI;
    end else if (!stat.full) begin
      op = OP_INSERT;
    end else begin
      op = OP_DROP;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.scan    = 1'b0;
    cmd.decide  = 1'b0;
    cmd.op      = OP_NONE;
    cmd.shdn    = 1'b0;
    cmd.shup    = 1'b0;
    cmd.publish = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        cmd.op     = op;
        case (op)
          OP_ALLOC_TAKE, OP_MERGE_BOTH: state_nxt = S_SHDN;
          OP_INSERT:                    state_nxt = S_SHUP;
          default:                      state_nxt = S_DONE;
        endcase
      end
      S_SHDN: begin
        cmd.shdn = 1'b1;
        if (stat.shdn_done) begin
          state_nxt = S_DONE;
        end
      end
      S_SHUP: begin
        cmd.shup = 1'b1;
        if (stat.shup_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/ffa_datapath.sv
// ---------------------------------------------------------------------------
// ffa_datapath: region table, counters and result register
// Pipelined table scan, entry shifts over one read and one write port.
// ---------------------------------------------------------------------------
module ffa_datapath import ffa_pkg::*; #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ffa_cmd_t    cmd,
  output ffa_stat_t   stat,
  input  logic        in_action,
  input  logic [31:0] in_block_addr,
  input  logic [31:0] in_block_size,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_alloc_addr,
  output logic [31:0] out_free_total,
  output logic [8:0]  out_entries_used,
  output logic [8:0]  out_entries_peak,
  output logic [31:0] out_lost_count,
  output logic [31:0] out_lost_bytes
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  // control state
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] peak_r, peak_nxt;
  logic [31:0]   total_r, total_nxt;
  logic [31:0]   lost_cnt_r, lost_cnt_nxt;
  logic [31:0]   lost_bytes_r, lost_bytes_nxt;
  logic          dv_r, dv_nxt;
  logic          ov_r, ov_nxt;

  // per-request working registers
  logic          act_r, act_nxt;
  logic [31:0]   addr_r, addr_nxt;
  logic [31:0]   size_r, size_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic          found_r, found_nxt;
  region_t       lo_r, lo_nxt;
  region_t       hi_r, hi_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic [31:0]   res_addr_r, res_addr_nxt;

  // result register
  logic [1:0]    o_status_r;
  logic [31:0]   o_addr_r, o_total_r, o_lost_cnt_r, o_lost_bytes_r;
  logic [8:0]    o_used_r, o_peak_r;

  // ram port
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  region_t       wr_data, rd_ent;

  logic          scan_issue, shup_issue, hit;
  logic [CW-1:0] ptr_inc, ptr_dec, i_dec, cnt_inc;
  logic [31:0]   lo_end, blk_end;

  ffa_ram #(
    .WIDTH ($bits(region_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_ent)
  );

  assign scan_issue = ptr_r < count_r;
  assign shup_issue = ptr_r > i_r;
  assign ptr_inc    = ptr_r + 1'b1;
  assign ptr_dec    = ptr_r - 1'b1;
  assign i_dec      = i_r - 1'b1;
  assign cnt_inc    = count_r + 1'b1;
  assign lo_end     = lo_r.start + lo_r.len;
  assign blk_end    = addr_r + size_r;
  assign hit        = dv_r && ((act_r == ACT_FREE) ? (rd_ent.start > addr_r)
                                                   : (rd_ent.len >= size_r));

  assign stat.scan_done = hit || (!dv_r && !scan_issue);
  assign stat.found     = found_r;
  assign stat.is_free   = (act_r == ACT_FREE);
  assign stat.lo_ok     = (i_r != '0) && (lo_end == addr_r);
  assign stat.hi_ok     = found_r && (blk_end == hi_r.start);
  assign stat.exact     = (hi_r.len == size_r);
  assign stat.full      = (count_r == FULL_COUNT);
  assign stat.shdn_done = !dv_r && !scan_issue;
  assign stat.shup_done = !dv_r && !shup_issue;
  assign stat.out_busy  = ov_r && !out_ready;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_r[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = i_r[AW-1:0];
    wr_data = '{start: addr_r, len: size_r};
    if (cmd.scan) begin
      rd_en = scan_issue;
    end
    if (cmd.shdn) begin
      rd_en   = scan_issue;
      rd_addr = ptr_inc[AW-1:0];
      wr_en   = dv_r;
      wr_addr = cur_r[AW-1:0];
      wr_data = rd_ent;
    end
    if (cmd.shup) begin
      rd_en   = shup_issue;
      rd_addr = ptr_dec[AW-1:0];
      if (dv_r) begin
        wr_en   = 1'b1;
        wr_addr = cur_r[AW-1:0];
        wr_data = rd_ent;
      end else if (!shup_issue) begin
        wr_en = 1'b1;
      end
    end
    if (cmd.decide) begin
      case (cmd.op)
        OP_ALLOC_TRIM: begin
          wr_en   = 1'b1;
          wr_data = '{start: hi_r.start + size_r, len: hi_r.len - size_r};
        end
        OP_MERGE_BOTH: begin
          wr_en   = 1'b1;
          wr_addr = i_dec[AW-1:0];
          wr_data = '{start: lo_r.start, len: lo_r.len + size_r + hi_r.len};
        end
        OP_MERGE_LO: begin
          wr_en   = 1'b1;
          wr_addr = i_dec[AW-1:0];
          wr_data = '{start: lo_r.start, len: lo_r.len + size_r};
        end
        OP_MERGE_HI: begin
          wr_en   = 1'b1;
          wr_data = '{start: addr_r, len: hi_r.len + size_r};
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    count_nxt      = count_r;
    peak_nxt       = peak_r;
    total_nxt      = total_r;
    lost_cnt_nxt   = lost_cnt_r;
    lost_bytes_nxt = lost_bytes_r;
    dv_nxt         = dv_r;
    ov_nxt         = ov_r;
    act_nxt        = act_r;
    addr_nxt       = addr_r;
    size_nxt       = size_r;
    ptr_nxt        = ptr_r;
    cur_nxt        = cur_r;
    i_nxt          = i_r;
    found_nxt      = found_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;

    if (cmd.load) begin
      act_nxt  = in_action;
      addr_nxt = in_block_addr;
      size_nxt = in_block_size;
      ptr_nxt  = '0;
      dv_nxt   = 1'b0;
    end

    if (cmd.scan) begin
      if (hit) begin
        found_nxt = 1'b1;
        i_nxt     = cur_r;
        hi_nxt    = rd_ent;
      end else if (!dv_r && !scan_issue) begin
        found_nxt = 1'b0;
        i_nxt     = count_r;
      end else begin
        if (dv_r) begin
          lo_nxt = rd_ent;
        end
        if (scan_issue) begin
          ptr_nxt = ptr_inc;
          cur_nxt = ptr_r;
        end
        dv_nxt = scan_issue;
      end
    end

    if (cmd.decide) begin
      dv_nxt         = 1'b0;
      res_status_nxt = STATUS_OK;
      res_addr_nxt   = '0;
      case (cmd.op)
        OP_ALLOC_FAIL: begin
          res_status_nxt = STATUS_NOFIT;
        end
        OP_ALLOC_TRIM: begin
          res_addr_nxt = hi_r.start;
          total_nxt    = total_r - size_r;
        end
        OP_ALLOC_TAKE: begin
          res_addr_nxt = hi_r.start;
          total_nxt    = total_r - size_r;
          count_nxt    = count_r - 1'b1;
          ptr_nxt      = i_r;
        end
        OP_MERGE_BOTH: begin
          total_nxt = total_r + size_r;
          count_nxt = count_r - 1'b1;
          ptr_nxt   = i_r;
        end
        OP_MERGE_LO, OP_MERGE_HI: begin
          total_nxt = total_r + size_r;
        end
        OP_INSERT: begin
          total_nxt = total_r + size_r;
          ptr_nxt   = count_r;
          count_nxt = cnt_inc;
          if (peak_r < cnt_inc) begin
            peak_nxt = cnt_inc;
          end
        end
        OP_DROP: begin
          res_status_nxt = STATUS_DROP;
          lost_cnt_nxt   = lost_cnt_r + 32'd1;
          lost_bytes_nxt = lost_bytes_r + size_r;
        end
        default: begin
          res_status_nxt = STATUS_OK;
        end
      endcase
    end

    // destination index in cur, source one above (down shift) or below (up shift)
    if (cmd.shdn) begin
      if (scan_issue) begin
        ptr_nxt = ptr_inc;
        cur_nxt = ptr_r;
      end
      dv_nxt = scan_issue;
    end

    if (cmd.shup) begin
      if (shup_issue) begin
        ptr_nxt = ptr_dec;
        cur_nxt = ptr_r;
      end
      dv_nxt = shup_issue;
    end

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    if (cmd.publish) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      peak_r       <= '0;
      total_r      <= '0;
      lost_cnt_r   <= '0;
      lost_bytes_r <= '0;
      dv_r         <= 1'b0;
      ov_r         <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      peak_r       <= peak_nxt;
      total_r      <= total_nxt;
      lost_cnt_r   <= lost_cnt_nxt;
      lost_bytes_r <= lost_bytes_nxt;
      dv_r         <= dv_nxt;
      ov_r         <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    addr_r       <= addr_nxt;
    size_r       <= size_nxt;
    ptr_r        <= ptr_nxt;
    cur_r        <= cur_nxt;
    i_r          <= i_nxt;
    found_r      <= found_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    if (cmd.publish) begin
      o_status_r     <= res_status_r;
      o_addr_r       <= res_addr_r;
      o_total_r      <= total_r;
      o_used_r       <= 9'(count_r);
      o_peak_r       <= 9'(peak_r);
      o_lost_cnt_r   <= lost_cnt_r;
      o_lost_bytes_r <= lost_bytes_r;
    end
  end

  assign out_valid        = ov_r;
  assign out_status       = o_status_r;
  assign out_alloc_addr   = o_addr_r;
  assign out_free_total   = o_total_r;
  assign out_entries_used = o_used_r;
  assign out_entries_peak = o_peak_r;
  assign out_lost_count   = o_lost_cnt_r;
  assign out_lost_bytes   = o_lost_bytes_r;

endmodule

// File: design/first_fit_free_list_allocator.sv
// ---------------------------------------------------------------------------
// first_fit_free_list_allocator: first-fit free-region allocator
// Address-sorted region table with carve-on-allocate and coalescing free.
// ---------------------------------------------------------------------------
// One request is in flight at a time. A request reads the region table one
// entry per cycle until the first fitting region (allocate) or the first
// region above the freed address (free) is found, or until all regions
// held have been read when nothing matches. Removing a used-up or merged
// region, or inserting a new one, then shifts the entries above it by one
// through the table RAM's single read and write port. The table needs no
// clearing after reset: only entries below the region count are read.
// A finished result is held in an output register, so the next request is
// taken as soon as the result has been loaded there.
// ---------------------------------------------------------------------------
module first_fit_free_list_allocator import ffa_pkg::*; #(
  parameter int TABLE_ENTRIES = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  ffa_in_if.sink    in_ch,
  ffa_out_if.source out_ch
);

  ffa_cmd_t  cmd;
  ffa_stat_t stat;
  logic      in_ready;

  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffa_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_action        (in_ch.action),
    .in_block_addr    (in_ch.block_addr),
    .in_block_size    (in_ch.block_size),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_status       (out_ch.status),
    .out_alloc_addr   (out_ch.alloc_addr),
    .out_free_total   (out_ch.free_total),
    .out_entries_used (out_ch.entries_used),
    .out_entries_peak (out_ch.entries_peak),
    .out_lost_count   (out_ch.lost_count),
    .out_lost_bytes   (out_ch.lost_bytes)
  );

  assign in_ch.ready = in_ready;

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request taken while previous request in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> !(out_ch.valid && !out_ch.ready))
    else $error("result register overwritten before transfer");

  a_fail_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status != STATUS_OK) |-> (out_ch.alloc_addr == '0))
    else $error("failed request reports nonzero address");

endmodule
